FILE: design/spte_pkg.sv
// Shared types, codes and microcode table of the sparse polynomial table evaluator.
package spte_pkg;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINNEG64 = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_LOAD,
    ST_ABS,
    ST_MUL,
    ST_MID,
    ST_FIX,
    ST_ADD,
    ST_RESULT
  } step_t;

  typedef enum logic [3:0] {
    DP_CLEAR,
    DP_IDLE,
    DP_NONE,
    DP_RDLOAD,
    DP_ABS,
    DP_MUL,
    DP_MID,
    DP_FIX,
    DP_ADD,
    DP_RESULT
  } dp_op_t;

  typedef enum logic [2:0] {
    JMP_SEQ,
    JMP_DISPATCH,
    JMP_LOOP,
    JMP_CLEAR,
    JMP_OUT
  } jmp_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
    jmp_t   jmp;
    step_t  target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t uw;
    uw = '{accept: 1'b0, op: DP_NONE, jmp: JMP_SEQ, target: ST_IDLE};
    unique case (pc)
      ST_CLEAR:   uw = '{accept: 1'b0, op: DP_CLEAR,  jmp: JMP_CLEAR,    target: ST_IDLE};
      ST_IDLE:    uw = '{accept: 1'b1, op: DP_IDLE,   jmp: JMP_DISPATCH, target: ST_IDLE};
      ST_RD_WAIT: uw = '{accept: 1'b0, op: DP_NONE,   jmp: JMP_SEQ,      target: ST_RD_LOAD};
      ST_RD_LOAD: uw = '{accept: 1'b0, op: DP_RDLOAD, jmp: JMP_SEQ,      target: ST_RESULT};
      ST_ABS:     uw = '{accept: 1'b0, op: DP_ABS,    jmp: JMP_SEQ,      target: ST_MUL};
      ST_MUL:     uw = '{accept: 1'b0, op: DP_MUL,    jmp: JMP_SEQ,      target: ST_MID};
      ST_MID:     uw = '{accept: 1'b0, op: DP_MID,    jmp: JMP_SEQ,      target: ST_FIX};
      ST_FIX:     uw = '{accept: 1'b0, op: DP_FIX,    jmp: JMP_SEQ,      target: ST_ADD};
      ST_ADD:     uw = '{accept: 1'b0, op: DP_ADD,    jmp: JMP_LOOP,     target: ST_RESULT};
      ST_RESULT:  uw = '{accept: 1'b0, op: DP_RESULT, jmp: JMP_OUT,      target: ST_IDLE};
      default:    uw = '{accept: 1'b0, op: DP_NONE,   jmp: JMP_SEQ,      target: ST_IDLE};
    endcase
    return uw;
  endfunction

endpackage

FILE: design/sparse_polynomial_table_eval_unit.sv
// Microcoded coefficient table with fixed-point Horner evaluation.
// Set and kind 3 words go straight to the result step, read words through a wait
// and a load step, evaluate words once round the table from the last entry down,
//   five steps per table entry (absolute value, two 32x32 multiplies, merge, floor, add).
// One word in flight; a result waiting on out_ready holds the next word in its last step.
// After reset the MAX_TERMS entries are cleared one entry a cycle, with in_ready low.
module sparse_polynomial_table_eval_unit #(
  parameter int MAX_TERMS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [5:0]         in_exponent,
  input  logic signed [31:0] in_coefficient,
  input  logic signed [31:0] in_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_coefficient_read,
  output logic signed [63:0] out_value,
  output logic               out_saturated
);
  import spte_pkg::*;

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TERMS - 1);

  logic [31:0]   coef_mem_r [MAX_TERMS];
  logic [31:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  step_t  pc_r, pc_nxt;
  ucode_t uc;

  logic [AW-1:0] addr_r, addr_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [31:0]   b_r, b_nxt;
  logic          xneg_r, xneg_nxt;
  logic          neg_r, neg_nxt;
  logic [63:0]   a_r, a_nxt;
  logic [63:0]   lo_r, lo_nxt;
  logic [63:0]   hi_r, hi_nxt;
  logic [63:0]   mid_r, mid_nxt;
  logic [15:0]   low16_r, low16_nxt;
  logic          rem_r, rem_nxt;
  logic [63:0]   p_r, p_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic          sat_r, sat_nxt;
  logic [31:0]   crd_r, crd_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_crd_r, out_crd_nxt;
  logic [63:0]   out_value_r, out_value_nxt;
  logic          out_sat_r, out_sat_nxt;

  logic          accept;
  logic          out_free;
  logic          exp_in_range;
  logic [63:0]   q;
  logic          q_big;
  logic [63:0]   addend;
  logic [63:0]   sum;

  assign uc           = ucode_rom(pc_r);
  assign in_ready     = uc.accept;
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign exp_in_range = 32'(in_exponent) < 32'(MAX_TERMS);

  assign q      = {mid_r[47:0], low16_r};
  assign q_big  = |mid_r[63:48];
  assign addend = {{16{rd_data_r[31]}}, rd_data_r, 16'h0000};
  assign sum    = p_r + addend;

  always_comb begin
    pc_nxt = pc_r;
    unique case (uc.jmp)
      JMP_SEQ: pc_nxt = uc.target;
      JMP_DISPATCH: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_READ: pc_nxt = ST_RD_WAIT;
            KIND_EVAL: pc_nxt = ST_ABS;
            default:   pc_nxt = ST_RESULT;
          endcase
        end
      end
      JMP_LOOP:  pc_nxt = (addr_r == '0) ? uc.target : ST_ABS;
      JMP_CLEAR: pc_nxt = (addr_r == LAST_ADDR) ? uc.target : pc_r;
      JMP_OUT:   pc_nxt = out_free ? uc.target : pc_r;
      default:   pc_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;
    addr_nxt      = addr_r;
    rd_ok_nxt     = rd_ok_r;
    b_nxt         = b_r;
    xneg_nxt      = xneg_r;
    neg_nxt       = neg_r;
    a_nxt         = a_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    low16_nxt     = low16_r;
    rem_nxt       = rem_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    crd_nxt       = crd_r;
    out_crd_nxt   = out_crd_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (uc.op)
      DP_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = AW'(addr_r + 1'b1);
      end
      DP_IDLE: begin
        if (accept) begin
          rd_ok_nxt = exp_in_range;
          b_nxt     = in_point[31] ? 32'(-in_point) : 32'(in_point);
          xneg_nxt  = in_point[31];
          acc_nxt   = '0;
          sat_nxt   = 1'b0;
          crd_nxt   = '0;
          addr_nxt  = (in_kind == KIND_EVAL) ? LAST_ADDR : AW'(in_exponent);
          if (in_kind == KIND_SET && in_coefficient != 0 && exp_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(in_exponent);
            mem_wdata = in_coefficient;
          end
        end
      end
      DP_NONE: ;
      DP_RDLOAD: crd_nxt = rd_ok_r ? rd_data_r : '0;
      DP_ABS: begin
        a_nxt   = acc_r[63] ? (~acc_r + 64'd1) : acc_r;
        neg_nxt = acc_r[63] ^ xneg_r;
      end
      DP_MUL: begin
        lo_nxt = 64'(a_r[31:0]) * 64'(b_r);
        hi_nxt = 64'(a_r[63:32]) * 64'(b_r);
      end
      DP_MID: begin
        mid_nxt   = hi_r + {32'h0, lo_r[63:32]};
        low16_nxt = lo_r[31:16];
        rem_nxt   = |lo_r[15:0];
      end
      DP_FIX: begin
        if (!neg_r) begin
          if (q_big || q[63]) begin
            p_nxt   = MAXPOS64;
            sat_nxt = 1'b1;
          end else begin
            p_nxt = q;
          end
        end else begin
          if (q_big || (q[63] && (rem_r || |q[62:0]))) begin
            p_nxt   = MINNEG64;
            sat_nxt = 1'b1;
          end else begin
            p_nxt = rem_r ? ~q : (~q + 64'd1);
          end
        end
      end
      DP_ADD: begin
        if (p_r[63] == addend[63] && sum[63] != p_r[63]) begin
          acc_nxt = p_r[63] ? MINNEG64 : MAXPOS64;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = sum;
        end
        if (addr_r != '0) begin
          addr_nxt = AW'(addr_r - 1'b1);
        end
      end
      DP_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_crd_nxt   = crd_r;
          out_value_nxt = acc_r;
          out_sat_nxt   = sat_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= coef_mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r     <= rd_ok_nxt;
    b_r         <= b_nxt;
    xneg_r      <= xneg_nxt;
    neg_r       <= neg_nxt;
    a_r         <= a_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    low16_r     <= low16_nxt;
    rem_r       <= rem_nxt;
    p_r         <= p_nxt;
    acc_r       <= acc_nxt;
    sat_r       <= sat_nxt;
    crd_r       <= crd_nxt;
    out_crd_r   <= out_crd_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_coefficient_read = out_crd_r;
  assign out_value            = out_value_r;
  assign out_saturated        = out_sat_r;

  a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_crd_r == '0 || (out_value_r == '0 && !out_sat_r)))
    else $error("read and evaluate result fields both nonzero");

  a_no_accept_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_ready)
    else $error("word accepted before table clear");

  a_hi_product_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_MID) |-> !hi_r[63])
    else $error("high partial product out of range");

  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_ADD && addr_r != '0) |=> (pc_r == ST_ABS))
    else $error("Horner loop left early");

endmodule
